[hw/rtl/fsme_pkg.sv]
// Shared types, codes and sizes of the table-driven state machine engine.
`default_nettype none
package fsme_pkg;

  localparam int unsigned MAX_TRANSITIONS = 32;
  localparam int unsigned SLOT_W          = $clog2(MAX_TRANSITIONS);
  localparam int unsigned CNT_W           = 6;
  localparam int unsigned GUARD_COUNT     = 7;
  localparam int unsigned STATE_W         = 8;
  localparam int unsigned STATE_NUM       = 1 << STATE_W;
  localparam int unsigned ACT_W           = 3;
  localparam int unsigned GSEL_W          = 3;

  localparam logic [STATE_W-1:0] INVALID_STATE = 8'hFF;

  // Request kinds.
  localparam logic [2:0] REQ_LOAD_TRANS = 3'd0;
  localparam logic [2:0] REQ_LOAD_ACT   = 3'd1;
  localparam logic [2:0] REQ_START      = 3'd2;
  localparam logic [2:0] REQ_EVENT      = 3'd3;
  localparam logic [2:0] REQ_SET_STATE  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_TAKEN     = 2'd0;
  localparam logic [1:0] ST_NO_MATCH  = 2'd1;
  localparam logic [1:0] ST_OUT_RANGE = 2'd2;
  localparam logic [1:0] ST_ACCEPTED  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_TRANS_COUNT = 1'b0;
  localparam logic CFG_INIT_STATE  = 1'b1;

  typedef struct packed {
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] ev;
    logic [STATE_W-1:0] to_state;
    logic [GSEL_W-1:0]  guard;
  } trans_entry_t;

  typedef struct packed {
    logic                we;
    logic [SLOT_W-1:0]   waddr;
    trans_entry_t        wdata;
    logic                re;
    logic [SLOT_W-1:0]   raddr;
  } tmem_req_t;

  typedef struct packed {
    logic                we;
    logic [STATE_W-1:0]  waddr;
    logic [ACT_W-1:0]    wdata;
    logic                re;
    logic [STATE_W-1:0]  raddr_a;
    logic [STATE_W-1:0]  raddr_b;
  } amem_req_t;

endpackage
`default_nettype wire

[hw/rtl/fsme_trans_store.sv]
// Transition table memory: one write port and one registered read port.
`default_nettype none
module fsme_trans_store
  import fsme_pkg::*;
(
  input  wire logic      clk_i,
  input  wire tmem_req_t req_i,
  output trans_entry_t   rdata_o
);

  trans_entry_t mem_q [MAX_TRANSITIONS];
  trans_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hw/rtl/fsme_act_store.sv]
// Per-state action flag memory with two registered read ports and reset valid bits.
`default_nettype none
module fsme_act_store
  import fsme_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire amem_req_t req_i,
  output logic [ACT_W-1:0] rdata_a_o,
  output logic [ACT_W-1:0] rdata_b_o
);

  logic [ACT_W-1:0]     mem_q [STATE_NUM];
  logic [STATE_NUM-1:0] valid_q;
  logic [ACT_W-1:0]     rdata_a_q, rdata_b_q;
  logic                 rvalid_a_q, rvalid_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_a_q  <= mem_q[req_i.raddr_a];
      rdata_b_q  <= mem_q[req_i.raddr_b];
      rvalid_a_q <= valid_q[req_i.raddr_a];
      rvalid_b_q <= valid_q[req_i.raddr_b];
    end
  end

  // A state never loaded since reset has no actions.
  assign rdata_a_o = rvalid_a_q ? rdata_a_q : '0;
  assign rdata_b_o = rvalid_b_q ? rdata_b_q : '0;

endmodule
`default_nettype wire

[hw/rtl/fsme_seq.sv]
// Sequencer: request decode, table scan, action lookup, state registers and result register.
`default_nettype none
module fsme_seq
  import fsme_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [7:0]       cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [2:0]       in_req_i,
  input  wire logic [41:0]      in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            out_status_o,
  output logic [23:0]           out_data_o,
  output tmem_req_t             tmem_o,
  input  wire trans_entry_t     tmem_rdata_i,
  output amem_req_t             amem_o,
  input  wire logic [ACT_W-1:0] act_cur_i,
  input  wire logic [ACT_W-1:0] act_prev_i
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_ACT_RD   = 3'd3;
  localparam logic [2:0] S_ACT_EVAL = 3'd4;
  localparam logic [2:0] S_RESULT   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic [STATE_W-1:0] cur_q, cur_d, prev_q, prev_d, lo_q, lo_d, hi_q, hi_d;
  logic [CNT_W-1:0]   cnt_q;
  logic [STATE_W-1:0] init_q;

  // Captured request fields.
  logic [2:0]          req_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [STATE_W-1:0]  sc_q, ec_q, nc_q;
  logic [GSEL_W-1:0]   gs_q;
  logic [ACT_W-1:0]    af_q;
  logic [GUARD_COUNT-1:0] gv_q;

  logic [SLOT_W-1:0]   idx_q, idx_d;
  logic [1:0]          res_status_q, res_status_d;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic [2:0]          res_fire_q, res_fire_d; // exit, entry, run

  logic [1:0]          out_status_q;
  logic [23:0]         out_data_q;

  logic                in_xfer, out_free;
  logic [CNT_W-1:0]    n_eff;
  logic                last_entry, guard_ok, hit, in_range;
  logic [GSEL_W-1:0]   gbit;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  assign n_eff = (cnt_q > CNT_W'(MAX_TRANSITIONS)) ? CNT_W'(MAX_TRANSITIONS) : cnt_q;
  assign last_entry = ({1'b0, idx_q} == (n_eff - CNT_W'(1)));
  assign in_range = (ec_q >= lo_q) && (ec_q <= hi_q);

  assign gbit = tmem_rdata_i.guard - GSEL_W'(1);
  assign guard_ok = (tmem_rdata_i.guard == '0) ||
                    ((gbit < GSEL_W'(GUARD_COUNT)) && gv_q[gbit]);
  assign hit = (tmem_rdata_i.from_state == cur_q) && (tmem_rdata_i.ev == ec_q) && guard_ok;

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cur_d        = cur_q;
    prev_d       = prev_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_fire_d   = res_fire_q;
    tmem_o       = '0;
    amem_o       = '0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_slot_d = '0;
        res_fire_d = '0;
        state_d    = S_RESULT;
        case (req_q)
          REQ_LOAD_TRANS: begin
            tmem_o.we    = ({1'b0, slot_q} < (SLOT_W + 1)'(MAX_TRANSITIONS));
            tmem_o.waddr = slot_q;
            tmem_o.wdata = '{from_state: sc_q, ev: ec_q, to_state: nc_q, guard: gs_q};
            if (ec_q < lo_q) lo_d = ec_q;
            if (ec_q > hi_q) hi_d = ec_q;
            res_status_d = ST_ACCEPTED;
          end
          REQ_LOAD_ACT: begin
            amem_o.we    = 1'b1;
            amem_o.waddr = sc_q;
            amem_o.wdata = af_q;
            res_status_d = ST_ACCEPTED;
          end
          REQ_START: begin
            cur_d        = init_q;
            prev_d       = INVALID_STATE;
            res_status_d = ST_TAKEN;
            state_d      = S_ACT_RD;
          end
          REQ_EVENT: begin
            if (!in_range) begin
              res_status_d = ST_OUT_RANGE;
            end else if (n_eff == '0) begin
              res_status_d = ST_NO_MATCH;
            end else begin
              tmem_o.re    = 1'b1;
              tmem_o.raddr = '0;
              idx_d        = '0;
              state_d      = S_SCAN;
            end
          end
          REQ_SET_STATE: begin
            cur_d        = sc_q;
            prev_d       = sc_q;
            res_status_d = ST_ACCEPTED;
          end
          default: begin
            res_status_d = ST_NO_MATCH;
          end
        endcase
      end
      S_SCAN: begin
        // Entry idx_q is on the read port; the next is fetched unless it hits or is last.
        if (hit) begin
          prev_d       = cur_q;
          cur_d        = tmem_rdata_i.to_state;
          res_slot_d   = idx_q;
          res_status_d = ST_TAKEN;
          state_d      = S_ACT_RD;
        end else if (last_entry) begin
          res_status_d = ST_NO_MATCH;
          state_d      = S_RESULT;
        end else begin
          tmem_o.re    = 1'b1;
          tmem_o.raddr = idx_q + SLOT_W'(1);
          idx_d        = idx_q + SLOT_W'(1);
        end
      end
      S_ACT_RD: begin
        amem_o.re      = 1'b1;
        amem_o.raddr_a = cur_q;
        amem_o.raddr_b = prev_q;
        state_d        = S_ACT_EVAL;
      end
      S_ACT_EVAL: begin
        if (prev_q != cur_q) begin
          res_fire_d = {(prev_q != INVALID_STATE) && act_prev_i[2], act_cur_i[0], act_cur_i[1]};
        end else begin
          res_fire_d = {1'b0, 1'b0, act_cur_i[1]};
        end
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cur_q       <= INVALID_STATE;
      prev_q      <= INVALID_STATE;
      lo_q        <= 8'hFF;
      hi_q        <= '0;
      cnt_q       <= '0;
      init_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TRANS_COUNT: cnt_q  <= cfg_data_i[CNT_W-1:0];
          CFG_INIT_STATE:  init_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q  <= in_req_i;
      slot_q <= in_data_i[4:0];
      sc_q   <= in_data_i[12:5];
      ec_q   <= in_data_i[20:13];
      nc_q   <= in_data_i[28:21];
      gs_q   <= in_data_i[31:29];
      af_q   <= in_data_i[34:32];
      gv_q   <= in_data_i[41:35];
    end
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_fire_q   <= res_fire_d;
    if (state_q == S_RESULT && out_free) begin
      out_status_q <= res_status_q;
      out_data_q   <= {res_slot_q, res_fire_q[0], res_fire_q[1], res_fire_q[2], prev_q, cur_q};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_data_o   = out_data_q;

  // The scan never runs past the searched part of the table.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> ({1'b0, idx_q} < n_eff))
    else $error("scan index beyond searched entries");

  // Once any transition is loaded the event range is well formed.
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lo_q <= hi_q) || (lo_q == 8'hFF && hi_q == '0))
    else $error("event bounds inverted");

  // Only a taken transition or a start reports actions or a slot.
  a_quiet_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != ST_TAKEN |-> out_data_q[23:16] == '0)
    else $error("actions reported without a transition");

  // The state registers change only while a request is being processed.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |=> $stable(cur_q) && $stable(prev_q))
    else $error("state changed while idle");

endmodule
`default_nettype wire

[hw/rtl/table_driven_fsm_engine_top.sv]
// Top level of the table-driven state machine engine.
`default_nettype none
// Programmable state machine: requests arrive as stream transfers (kind in s_axis_tuser),
// one result transfer per request leaves on the master side with its status in m_axis_tuser.
// One request is handled at a time. Loads, set-state and rejected events go from dispatch
// straight to the result register. An event scans entries in order until a match or the
// last of n, the programmed entry count limited to 32; a start and a matched event pass the
// action read and evaluation. The scan reads one transition table entry per cycle, which
// sets the event time; the action flags come from a second memory read once per taken step.
// A new request is accepted while the previous result still waits on the master side.
// Every state's action flags read as zero until loaded; no clearing pass follows reset.
// Configuration must be written only while the block is idle; the block does not enforce it.
module table_driven_fsm_engine_top
  import fsme_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // slot, state_code, event_code, next_state_code, guard_select, action_flags, guard_values
  input  wire logic [47:0] s_axis_tdata,
  // req_type
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // state_now, state_before, fire_exit, fire_entry, fire_run, matched_slot
  output logic [23:0]      m_axis_tdata,
  // status
  output logic [1:0]       m_axis_tuser
);

  tmem_req_t        tmem_req;
  trans_entry_t     tmem_rdata;
  amem_req_t        amem_req;
  logic [ACT_W-1:0] act_cur, act_prev;

  fsme_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_req_i     (s_axis_tuser),
    .in_data_i    (s_axis_tdata[41:0]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_data_o   (m_axis_tdata),
    .tmem_o       (tmem_req),
    .tmem_rdata_i (tmem_rdata),
    .amem_o       (amem_req),
    .act_cur_i    (act_cur),
    .act_prev_i   (act_prev)
  );

  fsme_trans_store u_trans (
    .clk_i   (clk_i),
    .req_i   (tmem_req),
    .rdata_o (tmem_rdata)
  );

  fsme_act_store u_act (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (amem_req),
    .rdata_a_o (act_cur),
    .rdata_b_o (act_prev)
  );

endmodule
`default_nettype wire
